>>> rtl/link_tx_token_retry_ctrl_core_assert.svh
// Assertion helpers for the transmit token/retry controller.
`ifndef LINK_TX_TOKEN_RETRY_CTRL_CORE_ASSERT_SVH
`define LINK_TX_TOKEN_RETRY_CTRL_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only out of reset.
`define LTRC_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked on every edge, reset included.
`define LTRC_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LTRC_ASSERT(name, clk, rstn, prop, msg)
`define LTRC_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

>>> rtl/ltrc_pkg.sv
package ltrc_pkg;

  // Link-side token budget and retry ring size, in flits.
  localparam int LinkBufFlits  = 64;
  localparam int RetryBufFlits = 256;

  localparam logic [6:0] LinkBufW  = 7'(LinkBufFlits);
  localparam logic [8:0] RetryBufW = 9'(RetryBufFlits);

  typedef enum logic [1:0] {
    REQ_SEND  = 2'd0,
    REQ_TOKEN = 2'd1,
    REQ_ACK   = 2'd2,
    REQ_FRP   = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    STALL_NONE   = 2'd0,
    STALL_BUSY   = 2'd1,
    STALL_TOKENS = 2'd2,
    STALL_RING   = 2'd3
  } stall_reason_e;

  typedef struct packed {
    req_type_e   req_type;
    logic [3:0]  pkt_len;
    logic        is_flow;
    logic        stage_idle;
    logic [4:0]  token_return;
    logic [7:0]  ptr_value;
  } item_t;

  typedef struct packed {
    logic          accepted;
    stall_reason_e stall_reason;
    logic [2:0]    seq_num;
    logic [7:0]    rrp_out;
    logic [7:0]    frp_out;
    logic [6:0]    tokens_left;
    logic          token_overflow;
  } result_t;

  // Handshake between the input register and the result register.
  typedef struct packed {
    logic fire;      // held transaction is processed this cycle
    logic drain_ok;  // result register can take a new result
  } pipe_ctrl_t;

endpackage

>>> rtl/ltrc_in_stage.sv
module ltrc_in_stage
  import ltrc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  item_t      item_i,
  input  pipe_ctrl_t ctrl_i,
  output pipe_ctrl_t ctrl_o,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  take;
  logic  fire;

  assign fire       = valid_q && ctrl_i.drain_ok;
  assign in_stall_o = valid_q && !fire;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (fire) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  always_comb begin
    ctrl_o          = ctrl_i;
    ctrl_o.fire     = fire;
  end

  assign item_o = item_q;

endmodule

>>> rtl/ltrc_engine.sv
`include "link_tx_token_retry_ctrl_core_assert.svh"

module ltrc_engine
  import ltrc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pipe_ctrl_t ctrl_i,
  input  item_t      item_i,
  output result_t    res_o
);

  logic [6:0] tokens_q, tokens_d;
  logic [7:0] wr_ptr_q, wr_ptr_d;
  logic [7:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] seq_q, seq_d;
  logic [7:0] rrp_q, rrp_d;

  logic [8:0] next_w;
  logic [8:0] wrap_w;
  logic [7:0] sum_tok;
  logic       ring_room;
  logic       tok_short;
  logic       tok_ovf;

  // Write pointer after this packet, one bit wider to see the wrap.
  assign next_w = {1'b0, wr_ptr_q} + 9'(item_i.pkt_len);
  assign wrap_w = (next_w >= RetryBufW) ? (next_w - RetryBufW) : next_w;

  assign ring_room = (wr_ptr_q >= rd_ptr_q) ?
                     ((next_w - {1'b0, rd_ptr_q}) < RetryBufW) :
                     ({1'b0, rd_ptr_q} > next_w);

  assign tok_short = !item_i.is_flow && (tokens_q < 7'(item_i.pkt_len));
  assign sum_tok   = {1'b0, tokens_q} + 8'(item_i.token_return);
  assign tok_ovf   = sum_tok > {1'b0, LinkBufW};

  always_comb begin
    tokens_d = tokens_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    seq_d    = seq_q;
    rrp_d    = rrp_q;
    res_o    = '0;

    unique case (item_i.req_type)
      REQ_SEND: begin
        if (!item_i.stage_idle) begin
          res_o.stall_reason = STALL_BUSY;
        end else if (tok_short) begin
          res_o.stall_reason = STALL_TOKENS;
        end else if (!ring_room) begin
          res_o.stall_reason = STALL_RING;
        end else begin
          res_o.accepted = 1'b1;
          res_o.seq_num  = seq_q;
          res_o.rrp_out  = rrp_q;
          res_o.frp_out  = wrap_w[7:0];
          seq_d          = seq_q + 3'd1;
          wr_ptr_d       = wrap_w[7:0];
          if (!item_i.is_flow) begin
            tokens_d = tokens_q - 7'(item_i.pkt_len);
          end
        end
      end
      REQ_TOKEN: begin
        res_o.token_overflow = tok_ovf;
        tokens_d = tok_ovf ? LinkBufW : sum_tok[6:0];
      end
      REQ_ACK: begin
        if ({1'b0, item_i.ptr_value} < RetryBufW) begin
          rd_ptr_d = item_i.ptr_value;
        end
      end
      REQ_FRP: begin
        rrp_d = item_i.ptr_value;
      end
      default: begin
        res_o = '0;
      end
    endcase

    res_o.tokens_left = tokens_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tokens_q <= LinkBufW;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      seq_q    <= '0;
      rrp_q    <= '0;
    end else if (ctrl_i.fire) begin
      tokens_q <= tokens_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      seq_q    <= seq_d;
      rrp_q    <= rrp_d;
    end
  end

  `LTRC_ASSERT(a_tokens_bound, clk_i, rst_ni, tokens_q <= LinkBufW, "tokens over budget")
  `LTRC_ASSERT(a_seq_step, clk_i, rst_ni, ctrl_i.fire |=> seq_q == $past(seq_d), "seq update lost")
  `LTRC_ASSERT(a_tok_hold, clk_i, rst_ni, !ctrl_i.fire |=> $stable(tokens_q), "tokens moved")
  `LTRC_ASSERT(a_wr_hold, clk_i, rst_ni, !ctrl_i.fire |=> $stable(wr_ptr_q), "wr ptr moved")

endmodule

>>> rtl/ltrc_out_stage.sv
module ltrc_out_stage
  import ltrc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pipe_ctrl_t ctrl_i,
  output pipe_ctrl_t ctrl_o,
  input  result_t    res_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output result_t    res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  always_comb begin
    ctrl_o          = '0;
    ctrl_o.drain_ok = !valid_q || !out_stall_i;
  end

  always_comb begin
    valid_d = valid_q && out_stall_i;
    if (ctrl_i.fire) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.fire) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> rtl/link_tx_token_retry_ctrl_core.sv
// Transmit-side link-layer token and retry-pointer controller.
// Input channel (in_valid_i / in_stall_o) carries one request per transaction:
// send head packet, token return, RRP acknowledge or FRP received.
// Output channel (out_valid_o / out_stall_i) returns exactly one result per
// request: accept flag, stall reason, stamped SEQ/RRP/FRP and token count.
// Path: a request is held in the input register, and its result is then
// captured in the result register. Throughput: one transaction per cycle
// while the output is not stalled; the token and pointer update is a single
// add/compare pass between the two registers.
// Reset: token count goes to the full link budget, write/read pointers,
// sequence counter and latched RRP go to zero; both channels come up empty.
// Output stall: the result register holds its transaction; the input
// register keeps its request until the result slot frees, and in_stall_o
// rises in the same cycle, so at most two transactions sit inside.
// The sequence number wraps from 7 to 0.
module link_tx_token_retry_ctrl_core
  import ltrc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // request channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic [3:0] pkt_len_i,
  input  logic       is_flow_i,
  input  logic       stage_idle_i,
  input  logic [4:0] token_return_i,
  input  logic [7:0] ptr_value_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       accepted_o,
  output logic [1:0] stall_reason_o,
  output logic [2:0] seq_num_o,
  output logic [7:0] rrp_out_o,
  output logic [7:0] frp_out_o,
  output logic [6:0] tokens_left_o,
  output logic       token_overflow_o
);

  item_t      in_item;
  item_t      held_item;
  result_t    eng_res;
  result_t    out_res;
  pipe_ctrl_t ctrl_from_out;  // drain_ok valid
  pipe_ctrl_t ctrl_from_in;   // fire valid, drain_ok passed along

  always_comb begin
    in_item.req_type     = req_type_e'(req_type_i);
    in_item.pkt_len      = pkt_len_i;
    in_item.is_flow      = is_flow_i;
    in_item.stage_idle   = stage_idle_i;
    in_item.token_return = token_return_i;
    in_item.ptr_value    = ptr_value_i;
  end

  ltrc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .ctrl_i     (ctrl_from_out),
    .ctrl_o     (ctrl_from_in),
    .item_o     (held_item)
  );

  // Token/pointer state and the per-request decision.
  ltrc_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl_from_in),
    .item_i (held_item),
    .res_o  (eng_res)
  );

  ltrc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      ({ctrl_from_in.fire, 1'b0}),
    .ctrl_o      (ctrl_from_out),
    .res_i       (eng_res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign accepted_o       = out_res.accepted;
  assign stall_reason_o   = out_res.stall_reason;
  assign seq_num_o        = out_res.seq_num;
  assign rrp_out_o        = out_res.rrp_out;
  assign frp_out_o        = out_res.frp_out;
  assign tokens_left_o    = out_res.tokens_left;
  assign token_overflow_o = out_res.token_overflow;

endmodule
